@@ rtl/ssd_pkg.sv @@
package ssd_pkg;

  // Display geometry and field widths
  localparam int unsigned DIGIT_COUNT = 3;
  localparam int unsigned DIGIT_W     = $clog2(DIGIT_COUNT);
  localparam int unsigned SEG_W       = 8;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF   = 1'b1;

  // Configuration reset values
  localparam logic [CNT_W-1:0] IDLE_TIMEOUT_RST = 16'd2000;
  localparam logic [CNT_W-1:0] BLINK_HALF_RST   = 16'd100;

  // Segment codes
  localparam logic [SEG_W-1:0] SEG_NONE = 8'h00;
  localparam logic [SEG_W-1:0] SEG_E    = 8'h79;

  // Fault code clamp range
  localparam logic [7:0] FAULT_MIN = 8'd1;
  localparam logic [7:0] FAULT_MAX = 8'd20;
  localparam logic [7:0] SOC_FULL  = 8'd100;

  // Segment bytes of one display, ones digit at index 0
  typedef logic [DIGIT_COUNT-1:0][SEG_W-1:0] digits_t;

  typedef struct packed {
    digits_t charge;
    digits_t fault;
  } enc_t;

  typedef struct packed {
    logic [CNT_W-1:0] idle_timeout;
    logic [CNT_W-1:0] blink_half;
  } cfg_t;

  localparam digits_t CHARGE_RST = {SEG_NONE, SEG_NONE, 8'h3F};
  localparam digits_t FAULT_RST  = {SEG_E, 8'h3F, 8'h06};

  // Decimal digit to segment byte
  function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_NONE;
    endcase
    return s;
  endfunction

  // Split a value below 100 into tens and ones: tens by reciprocal multiply
  function automatic logic [7:0] dec_split(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens10;
    logic [3:0]  ones;
    prod   = {8'd0, v} * 15'd205;
    tens   = prod[14:11];
    tens10 = {3'd0, tens} * 7'd10;
    ones   = 4'(v - tens10);
    return {tens, ones};
  endfunction

endpackage

@@ rtl/ssd_encode.sv @@
module ssd_encode
  import ssd_pkg::*;
(
  input  logic [7:0] charge_percent_i,
  input  logic [7:0] fault_number_i,
  output enc_t       enc_o
);

  logic [7:0] soc_split;
  logic [7:0] fault_clamp;
  logic [7:0] fault_split;

  assign soc_split = dec_split(charge_percent_i[6:0]);

  // Fault digits: clamp the code, then E, tens, ones
  always_comb begin
    if (fault_number_i < FAULT_MIN) begin
      fault_clamp = FAULT_MIN;
    end else if (fault_number_i > FAULT_MAX) begin
      fault_clamp = FAULT_MAX;
    end else begin
      fault_clamp = fault_number_i;
    end
  end

  assign fault_split = dec_split(fault_clamp[6:0]);

  // Charge digits: full scale shows as 1 0 0, else blank leading zero
  always_comb begin
    if (charge_percent_i >= SOC_FULL) begin
      enc_o.charge = {seg_font(4'd1), seg_font(4'd0), seg_font(4'd0)};
    end else begin
      enc_o.charge[0] = seg_font(soc_split[3:0]);
      enc_o.charge[1] = (soc_split[7:4] == 4'd0) ? SEG_NONE : seg_font(soc_split[7:4]);
      enc_o.charge[2] = SEG_NONE;
    end
    enc_o.fault[0] = seg_font(fault_split[3:0]);
    enc_o.fault[1] = (fault_split[7:4] == 4'd0) ? SEG_NONE : seg_font(fault_split[7:4]);
    enc_o.fault[2] = SEG_E;
  end

endmodule

@@ rtl/ssd_scan.sv @@
module ssd_scan
  import ssd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             command_i,
  input  logic             show_fault_i,
  input  logic             wake_n_i,
  input  enc_t             enc_i,
  input  cfg_t             cfg_i,
  output logic [SEG_W-1:0] segments_o,
  output logic [2:0]       digit_enable_o
);

  logic                   fault_mode_q, fault_mode_d;
  digits_t                charge_q, charge_d;
  digits_t                fault_q, fault_d;
  logic [CNT_W-1:0]       blink_cnt_q, blink_cnt_d;
  logic                   phase_q, phase_d;
  logic [DIGIT_W-1:0]     scan_q, scan_d;
  logic [CNT_W-1:0]       idle_cnt_q, idle_cnt_d;
  logic                   on_q, on_d;
  logic [SEG_W-1:0]       latched_q, latched_d;
  logic [2:0]             pins_q, pins_d;

  logic [CNT_W-1:0]       idle_inc;
  logic [CNT_W-1:0]       blink_inc;
  logic [DIGIT_W-1:0]     idx;
  logic [SEG_W-1:0]       seg;

  assign idle_inc  = idle_cnt_q + 1'b1;
  assign blink_inc = blink_cnt_q + 1'b1;
  assign idx       = (scan_q >= DIGIT_W'(DIGIT_COUNT)) ? '0 : scan_q;

  // Per beat: an update loads caches, a tick scans a digit or blanks pins
  always_comb begin
    fault_mode_d = fault_mode_q;
    charge_d     = charge_q;
    fault_d      = fault_q;
    blink_cnt_d  = blink_cnt_q;
    phase_d      = phase_q;
    scan_d       = scan_q;
    idle_cnt_d   = idle_cnt_q;
    on_d         = on_q;
    latched_d    = latched_q;
    pins_d       = pins_q;
    seg          = SEG_NONE;

    if (command_i) begin
      fault_mode_d = show_fault_i;
      charge_d     = enc_i.charge;
      if (show_fault_i) begin
        fault_d = enc_i.fault;
      end
    end else begin
      // Idle timeout, then wake override
      idle_cnt_d = idle_inc;
      if (idle_inc >= cfg_i.idle_timeout) begin
        idle_cnt_d = '0;
        on_d       = 1'b0;
      end
      if (!wake_n_i) begin
        idle_cnt_d = '0;
        on_d       = 1'b1;
      end

      if (!on_d) begin
        pins_d = '0;
        scan_d = '0;
      end else begin
        // Advance blink phase in fault mode, hold at zero otherwise
        if (fault_mode_q) begin
          blink_cnt_d = blink_inc;
          if (blink_inc >= cfg_i.blink_half) begin
            blink_cnt_d = '0;
            phase_d     = ~phase_q;
          end
        end else begin
          blink_cnt_d = '0;
          phase_d     = 1'b0;
        end

        seg       = (fault_mode_q && !phase_d) ? fault_q[idx] : charge_q[idx];
        latched_d = seg;
        pins_d    = (seg != SEG_NONE) ? (3'b100 >> idx) : 3'b000;
        scan_d    = (idx == DIGIT_W'(DIGIT_COUNT - 1)) ? '0 : idx + 1'b1;
      end
    end
  end

  // Commit state on an advancing beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_mode_q <= 1'b0;
      charge_q     <= CHARGE_RST;
      fault_q      <= FAULT_RST;
      blink_cnt_q  <= '0;
      phase_q      <= 1'b0;
      scan_q       <= '0;
      idle_cnt_q   <= '0;
      on_q         <= 1'b1;
      latched_q    <= SEG_NONE;
      pins_q       <= '0;
    end else if (adv_i) begin
      fault_mode_q <= fault_mode_d;
      charge_q     <= charge_d;
      fault_q      <= fault_d;
      blink_cnt_q  <= blink_cnt_d;
      phase_q      <= phase_d;
      scan_q       <= scan_d;
      idle_cnt_q   <= idle_cnt_d;
      on_q         <= on_d;
      latched_q    <= latched_d;
      pins_q       <= pins_d;
    end
  end

  assign segments_o     = latched_q;
  assign digit_enable_o = pins_q;

endmodule

@@ rtl/three_digit_seven_segment_scanner_core.sv @@
// Three-digit multiplexed seven-segment display driver, common cathode.
// Input channel (in_valid_i/in_ready_o): one beat is either an update
// (command_i = 1: mode, charge percent, fault code) or a scan tick
// (command_i = 0, with the active-low wake_n_i). Every input beat gives
// exactly one output beat (out_valid_o/out_ready_i) carrying the latched
// segment byte and the three digit drive pins; an update repeats the
// current latch; a tick scans the next digit, or blanks the pins when off.
// Configuration channel (cfg_valid_i/cfg_ready_o) is always ready; index 0
// sets the idle timeout, index 1 the blink half period, both in ticks.
// Write it only while no beat is in flight.
// The input register feeds the state update, whose registers drive the
// outputs. Throughput is one beat per cycle. If the receiver stalls,
// the output beat holds, the input register fills, and in_ready_o drops
// until it drains.
// Reset clears both stages, restores the register defaults (2000, 100),
// shows 0 in charge mode, and turns the display on with all pins off.
module three_digit_seven_segment_scanner_core
  import ssd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic                 show_fault_i,
  input  logic [7:0]           charge_percent_i,
  input  logic [7:0]           fault_number_i,
  input  logic                 wake_n_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SEG_W-1:0]     segments_o,
  output logic [2:0]           digit_enable_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  logic       in_valid_q;
  logic       command_q;
  logic       show_fault_q;
  logic [7:0] charge_percent_q;
  logic [7:0] fault_number_q;
  logic       wake_n_q;
  logic       out_valid_q;
  logic       adv;
  cfg_t       cfg_q;
  enc_t       enc;

  // Stage handshake: advance when the output slot is free or being taken
  assign adv         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      command_q        <= command_i;
      show_fault_q     <= show_fault_i;
      charge_percent_q <= charge_percent_i;
      fault_number_q   <= fault_number_i;
      wake_n_q         <= wake_n_i;
    end
  end

  // Output beat valid: set on advance, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout <= IDLE_TIMEOUT_RST;
      cfg_q.blink_half   <= BLINK_HALF_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_data_i;
        CFG_BLINK_HALF:   cfg_q.blink_half   <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  ssd_encode u_encode (
    .charge_percent_i (charge_percent_q),
    .fault_number_i   (fault_number_q),
    .enc_o            (enc)
  );

  ssd_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .command_i      (command_q),
    .show_fault_i   (show_fault_q),
    .wake_n_i       (wake_n_q),
    .enc_i          (enc),
    .cfg_i          (cfg_q),
    .segments_o     (segments_o),
    .digit_enable_o (digit_enable_o)
  );

endmodule

@@ rtl/ssd_checker.sv @@
module ssd_checker
  import ssd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [SEG_W-1:0]     segments_o,
  input logic [2:0]           digit_enable_o
);

  // A stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(segments_o)
      && $stable(digit_enable_o))
    else $error("output beat changed while stalled");

  // At most one digit driven at a time
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(digit_enable_o))
    else $error("more than one digit enabled");

  // A driven digit never shows a blank byte
  a_no_blank_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && digit_enable_o != 3'b000 |-> segments_o != SEG_NONE)
    else $error("digit enabled with blank segments");

  // The unused segment bit stays low
  a_bit7_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !segments_o[7])
    else $error("segment bit 7 set");

  // The input stalls only behind a stalled output beat
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with the output free");

endmodule

bind three_digit_seven_segment_scanner_core ssd_checker u_ssd_checker (.*);
